@@ rtl/sbwu_pkg.sv @@
// Shared types, constants and divider tables for the soft-bound weight update.
`default_nettype none

package sbwu_pkg;

  typedef enum logic [1:0] {
    ST_OK          = 2'd0,
    ST_EMPTY_BAND  = 2'd1,
    ST_OUT_OF_BAND = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    CFG_LOWER = 2'd0,
    CFG_UPPER = 2'd1,
    CFG_RATE  = 2'd2
  } cfg_reg_e;

  localparam int unsigned CFG_IDX_BITS = 2;
  localparam int unsigned RATE_BITS    = 32;
  localparam logic [RATE_BITS-1:0] RATE_RESET = 32'd6554;

  // exponent cap and the Q4.28 point of the series argument
  localparam int unsigned EXP_CAP = 12;
  localparam int unsigned Y_FRAC  = 28;

  // decay is unsigned Q0.16, 1.0 included
  localparam int unsigned DEC_FRAC = 16;
  localparam int unsigned DEC_BITS = DEC_FRAC + 1;

  localparam int unsigned TERMS     = 13;
  localparam int unsigned SQUARINGS = 4;

  localparam int unsigned ARG_LAT    = 3;
  localparam int unsigned SERIES_LAT = 2 * TERMS;
  localparam int unsigned SQUARE_LAT = 2 * SQUARINGS + 1;
  localparam int unsigned BLEND_LAT  = 2;
  localparam int unsigned MID_LAT    = SERIES_LAT + SQUARE_LAT;
  localparam int unsigned TOTAL_LAT  = ARG_LAT + MID_LAT + BLEND_LAT;
  localparam int unsigned CNT_BITS   = $clog2(TOTAL_LAT + 1);

  typedef struct packed {
    status_e status;
    logic    neg;
    logic    dec_zero;
    logic    dec_one;
  } ctl_t;

  // floor(p / n) = (p * div_magic(n)) >> div_shift(n), exact for any 32-bit p
  function automatic logic [32:0] div_magic(input int unsigned n);
    logic [32:0] m;
    case (n)
      1, 2, 4, 8: m = 33'd4294967296;
      3, 6, 12:   m = 33'd5726623062;
      5, 10:      m = 33'd6871947674;
      7:          m = 33'd4908534053;
      9:          m = 33'd7635497416;
      11:         m = 33'd6247225158;
      13:         m = 33'd5286113596;
      default:    m = 33'd4294967296;
    endcase
    return m;
  endfunction

  function automatic int unsigned div_shift(input int unsigned n);
    int unsigned s;
    case (n)
      1:                   s = 32;
      2:                   s = 33;
      3, 4:                s = 34;
      5, 6, 7, 8:          s = 35;
      9, 10, 11, 12, 13:   s = 36;
      default:             s = 32;
    endcase
    return s;
  endfunction

endpackage

`default_nettype wire

@@ rtl/sbwu_arg.sv @@
// Front stages: band checks, drive magnitude, exponent product and series argument.
`default_nettype none

module sbwu_arg #(
  parameter int unsigned FRAC_BITS = 16,
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        valid_i,
  input  logic signed [DATA_BITS-1:0] weight_i,
  input  logic signed [DATA_BITS-1:0] drive_i,
  input  logic signed [DATA_BITS-1:0] lower_i,
  input  logic signed [DATA_BITS-1:0] upper_i,
  input  logic [31:0]                 rate_i,
  output logic                        valid_o,
  output logic [31:0]                 y_o,
  output sbwu_pkg::ctl_t              ctl_o,
  output logic [DATA_BITS-1:0]        base_o,
  output logic [DATA_BITS-1:0]        diff_o
);
  import sbwu_pkg::*;

  localparam int unsigned H    = (DATA_BITS + 1) / 2;
  localparam int unsigned HH   = DATA_BITS - H;
  localparam int unsigned PLW  = RATE_BITS + H;
  localparam int unsigned PHW  = RATE_BITS + HH;
  localparam int unsigned XW_A = RATE_BITS + DATA_BITS;
  localparam int unsigned XW_B = 2 * FRAC_BITS + 5;
  localparam int unsigned XW   = (XW_A > XW_B) ? XW_A : XW_B;
  localparam int unsigned YSR  = (2 * FRAC_BITS >= Y_FRAC) ? 2 * FRAC_BITS - Y_FRAC : 0;
  localparam int unsigned YSL  = (2 * FRAC_BITS < Y_FRAC) ? Y_FRAC - 2 * FRAC_BITS : 0;
  localparam logic [XW-1:0] LIM = XW'(EXP_CAP) << (2 * FRAC_BITS);

  logic [ARG_LAT-1:0] v_q;

  // stage A
  logic                 empty, outside, bypass, neg;
  status_e              status;
  logic [DATA_BITS-1:0] mag, base, diff;
  ctl_t                 a_ctl_d;
  logic [DATA_BITS-1:0] a_mag_q, a_base_q, a_diff_q;
  ctl_t                 a_ctl_q;

  // stage B
  logic [PLW-1:0]       plo_q;
  logic [PHW-1:0]       phi_q;
  logic [DATA_BITS-1:0] b_base_q, b_diff_q;
  ctl_t                 b_ctl_q;

  // stage C
  logic [XW-1:0]        x;
  logic [31:0]          y;
  ctl_t                 c_ctl_d;
  logic [31:0]          y_q;
  logic [DATA_BITS-1:0] c_base_q, c_diff_q;
  ctl_t                 c_ctl_q;

  always_comb begin
    empty   = (lower_i >= upper_i);
    outside = (weight_i < lower_i) || (weight_i > upper_i);
    neg     = drive_i[DATA_BITS-1];
    bypass  = empty || outside || (drive_i == '0);
    status  = ST_OK;
    if (empty) begin
      status = ST_EMPTY_BAND;
    end else if (outside) begin
      status = ST_OUT_OF_BAND;
    end
    mag = neg ? DATA_BITS'(-drive_i) : drive_i;
    if (bypass) begin
      base = weight_i;
      diff = '0;
    end else if (neg) begin
      base = lower_i;
      diff = weight_i - lower_i;
    end else begin
      base = upper_i;
      diff = upper_i - weight_i;
    end
    a_ctl_d = '{status: status, neg: neg, dec_zero: 1'b0, dec_one: 1'b0};
  end

  always_comb begin
    x = (XW'(phi_q) << H) + XW'(plo_q);
    y = 32'((x >> YSR) << YSL);
    c_ctl_d          = b_ctl_q;
    c_ctl_d.dec_zero = (x > LIM);
    c_ctl_d.dec_one  = (y == '0);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[ARG_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    a_mag_q  <= mag;
    a_base_q <= base;
    a_diff_q <= diff;
    a_ctl_q  <= a_ctl_d;

    plo_q    <= PLW'(rate_i) * PLW'(a_mag_q[H-1:0]);
    phi_q    <= PHW'(rate_i) * PHW'(a_mag_q[DATA_BITS-1:H]);
    b_base_q <= a_base_q;
    b_diff_q <= a_diff_q;
    b_ctl_q  <= a_ctl_q;

    y_q      <= y;
    c_base_q <= b_base_q;
    c_diff_q <= b_diff_q;
    c_ctl_q  <= c_ctl_d;
  end

  assign valid_o = v_q[ARG_LAT-1];
  assign y_o     = y_q;
  assign ctl_o   = c_ctl_q;
  assign base_o  = c_base_q;
  assign diff_o  = c_diff_q;

endmodule

`default_nettype wire

@@ rtl/sbwu_series.sv @@
// Pipelined Taylor series of exp(-y) in Q0.32, one multiply and one divide stage per term after the first.
`default_nettype none

module sbwu_series (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        valid_i,
  input  logic [31:0] y_i,
  output logic        valid_o,
  output logic [31:0] u_o
);
  import sbwu_pkg::*;

  localparam int unsigned SW = 35;
  localparam logic signed [SW-1:0] S_ONE = {{(SW - 33){1'b0}}, 1'b1, 32'd0};

  logic [SERIES_LAT-1:0] v_q;

  logic [31:0]          y0_q;
  logic signed [SW-1:0] s1_q;

  logic [31:0]          ym_q [2:TERMS];
  logic [63:0]          pm_q [2:TERMS];
  logic signed [SW-1:0] sm_q [2:TERMS];
  logic [31:0]          yd_q [2:TERMS];
  logic [64:0]          qp_q [2:TERMS];
  logic signed [SW-1:0] sd_q [2:TERMS];

  // t_prev[n] is term n-1, s_src[n] the sum through term n-1
  logic [31:0]          t_prev [2:TERMS+1];
  logic signed [SW-1:0] s_src  [2:TERMS+1];
  logic [31:0]          y_src  [2:TERMS];
  logic signed [SW-1:0] s_fin;
  logic [31:0]          u_q;

  always_comb begin
    t_prev[2] = y0_q;
    s_src[2]  = s1_q;
    y_src[2]  = y0_q;
    for (int n = 3; n <= TERMS + 1; n++) begin
      t_prev[n] = 32'(qp_q[n-1] >> div_shift(n - 1));
      if ((n - 1) % 2 == 1) begin
        s_src[n] = sd_q[n-1] - SW'(t_prev[n]);
      end else begin
        s_src[n] = sd_q[n-1] + SW'(t_prev[n]);
      end
    end
    for (int n = 3; n <= TERMS; n++) begin
      y_src[n] = yd_q[n-1];
    end
    s_fin = s_src[TERMS+1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[SERIES_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    y0_q <= y_i;
    s1_q <= S_ONE - SW'(y_i);
    for (int n = 2; n <= TERMS; n++) begin
      pm_q[n] <= 64'(t_prev[n]) * 64'(y_src[n]);
      ym_q[n] <= y_src[n];
      sm_q[n] <= s_src[n];
      qp_q[n] <= 65'(pm_q[n][63:32]) * 65'(div_magic(n));
      yd_q[n] <= ym_q[n];
      sd_q[n] <= sm_q[n];
    end
    if (s_fin < 0) begin
      u_q <= '0;
    end else if (s_fin[SW-1:32] != '0) begin
      u_q <= '1;
    end else begin
      u_q <= s_fin[31:0];
    end
  end

  assign valid_o = v_q[SERIES_LAT-1];
  assign u_o     = u_q;

endmodule

`default_nettype wire

@@ rtl/sbwu_square.sv @@
// Four rounded squarings in Q0.32 and the final rounding of the decay to Q0.16.
`default_nettype none

module sbwu_square (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  logic [31:0]                   u_i,
  output logic                          valid_o,
  output logic [sbwu_pkg::DEC_BITS-1:0] dec_o
);
  import sbwu_pkg::*;

  localparam int unsigned DEC_SHIFT = 32 - DEC_FRAC;
  localparam logic [32:0] DEC_HALF  = 33'd1 << (DEC_SHIFT - 1);

  logic [SQUARE_LAT-1:0] v_q;
  logic [31:0]           src  [SQUARINGS];
  logic [32:0]           rnd  [SQUARINGS];
  logic [63:0]           sq_q [SQUARINGS];
  logic [31:0]           r_q  [SQUARINGS];
  logic [DEC_BITS-1:0]   dec_q;

  always_comb begin
    src[0] = u_i;
    for (int i = 1; i < SQUARINGS; i++) begin
      src[i] = r_q[i-1];
    end
    for (int i = 0; i < SQUARINGS; i++) begin
      rnd[i] = {1'b0, sq_q[i][63:32]} + 33'(sq_q[i][31]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      v_q <= {v_q[SQUARE_LAT-2:0], valid_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < SQUARINGS; i++) begin
      sq_q[i] <= 64'(src[i]) * 64'(src[i]);
      r_q[i]  <= rnd[i][32] ? '1 : rnd[i][31:0];
    end
    dec_q <= DEC_BITS'(({1'b0, r_q[SQUARINGS-1]} + DEC_HALF) >> DEC_SHIFT);
  end

  assign valid_o = v_q[SQUARE_LAT-1];
  assign dec_o   = dec_q;

endmodule

`default_nettype wire

@@ rtl/sbwu_blend.sv @@
// Back stages: scale the distance to the bound by the decay and step from the bound.
`default_nettype none

module sbwu_blend #(
  parameter int unsigned DATA_BITS = 32
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          valid_i,
  input  sbwu_pkg::ctl_t                ctl_i,
  input  logic [DATA_BITS-1:0]          base_i,
  input  logic [DATA_BITS-1:0]          diff_i,
  input  logic [sbwu_pkg::DEC_BITS-1:0] dec_i,
  output logic                          valid_o,
  output logic [DATA_BITS-1:0]          weight_o,
  output sbwu_pkg::status_e             status_o
);
  import sbwu_pkg::*;

  localparam int unsigned PW = DATA_BITS + DEC_BITS;
  localparam logic [DEC_BITS-1:0] DEC_ONE = DEC_BITS'(1) << DEC_FRAC;

  logic [DEC_BITS-1:0]  dec_eff;
  logic [DATA_BITS-1:0] step;
  logic [PW-1:0]        pr_q;
  logic [DATA_BITS-1:0] p_base_q;
  ctl_t                 p_ctl_q;
  logic                 p_v_q, o_v_q;
  logic [DATA_BITS-1:0] weight_q;
  status_e              status_q;

  always_comb begin
    if (ctl_i.dec_zero) begin
      dec_eff = '0;
    end else if (ctl_i.dec_one) begin
      dec_eff = DEC_ONE;
    end else begin
      dec_eff = dec_i;
    end
    step = DATA_BITS'(pr_q >> DEC_FRAC);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_v_q <= 1'b0;
      o_v_q <= 1'b0;
    end else begin
      p_v_q <= valid_i;
      o_v_q <= p_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    pr_q     <= PW'(diff_i) * PW'(dec_eff);
    p_base_q <= base_i;
    p_ctl_q  <= ctl_i;
    // toward lower bound adds, toward upper bound subtracts
    weight_q <= p_ctl_q.neg ? p_base_q + step : p_base_q - step;
    status_q <= p_ctl_q.status;
  end

  assign valid_o  = o_v_q;
  assign weight_o = weight_q;
  assign status_o = status_q;

endmodule

`default_nettype wire

@@ rtl/soft_bound_weight_update.sv @@
// Top level of the soft-bound weight update: config registers, pipeline and side-band delay.
//
//   channel   direction  handshake                    word
//   item      in         start && !busy               weight_in_i, drive_i
//   result    out        done_o (one-cycle strobe)    weight_out_o, status_o
//   config    in         cfg_valid_i && cfg_ready_o   cfg_index_i, cfg_data_i
//
// One item per cycle; the path from item to result runs through the 26-stage Taylor
// series, the 9 squaring stages and 5 front and back stages.
// busy stays low: the pipeline never stalls and the result side cannot hold off.
// cfg_ready_o is high only while no item is in flight or offered on start.
// Reset clears the valid bits and the in-flight count and loads lower 0, upper 1.0, RATE_RESET.
`default_nettype none

module soft_bound_weight_update #(
  parameter  int unsigned FRAC_BITS = 16,
  parameter  int unsigned DATA_BITS = 32,
  localparam int unsigned CFG_BITS  = (DATA_BITS > 32) ? DATA_BITS : 32
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic signed [DATA_BITS-1:0]         weight_in_i,
  input  logic signed [DATA_BITS-1:0]         drive_i,
  output logic                                done_o,
  output logic signed [DATA_BITS-1:0]         weight_out_o,
  output sbwu_pkg::status_e                   status_o,
  input  logic                                cfg_valid_i,
  output logic                                cfg_ready_o,
  input  logic [sbwu_pkg::CFG_IDX_BITS-1:0]   cfg_index_i,
  input  logic [CFG_BITS-1:0]                 cfg_data_i
);
  import sbwu_pkg::*;

  logic signed [DATA_BITS-1:0] lower_q, upper_q;
  logic [RATE_BITS-1:0]        rate_q;
  logic                        in_acc;
  logic [CNT_BITS-1:0]         inflight_q, inflight_d;

  logic                 arg_v;
  logic [31:0]          arg_y;
  ctl_t                 arg_ctl;
  logic [DATA_BITS-1:0] arg_base, arg_diff;

  logic                 ser_v;
  logic [31:0]          ser_u;
  logic                 sq_v;
  logic [DEC_BITS-1:0]  sq_dec;

  logic [DATA_BITS-1:0] base_dly_q [MID_LAT];
  logic [DATA_BITS-1:0] diff_dly_q [MID_LAT];
  ctl_t                 ctl_dly_q  [MID_LAT];
  logic [DATA_BITS-1:0] weight_out;

  assign busy   = 1'b0;
  assign in_acc = start && !busy;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lower_q <= '0;
      upper_q <= DATA_BITS'(1) << FRAC_BITS;
      rate_q  <= RATE_RESET;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_reg_e'(cfg_index_i))
        CFG_LOWER: lower_q <= cfg_data_i[DATA_BITS-1:0];
        CFG_UPPER: upper_q <= cfg_data_i[DATA_BITS-1:0];
        CFG_RATE:  rate_q  <= cfg_data_i[RATE_BITS-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    inflight_d = inflight_q;
    if (in_acc && !done_o) begin
      inflight_d = inflight_q + 1'b1;
    end else if (!in_acc && done_o) begin
      inflight_d = inflight_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      inflight_q <= '0;
    end else begin
      inflight_q <= inflight_d;
    end
  end

  assign cfg_ready_o = (inflight_q == '0) && !start;

  sbwu_arg #(
    .FRAC_BITS (FRAC_BITS),
    .DATA_BITS (DATA_BITS)
  ) u_arg (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (in_acc),
    .weight_i (weight_in_i),
    .drive_i  (drive_i),
    .lower_i  (lower_q),
    .upper_i  (upper_q),
    .rate_i   (rate_q),
    .valid_o  (arg_v),
    .y_o      (arg_y),
    .ctl_o    (arg_ctl),
    .base_o   (arg_base),
    .diff_o   (arg_diff)
  );

  sbwu_series u_series (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (arg_v),
    .y_i     (arg_y),
    .valid_o (ser_v),
    .u_o     (ser_u)
  );

  sbwu_square u_square (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (ser_v),
    .u_i     (ser_u),
    .valid_o (sq_v),
    .dec_o   (sq_dec)
  );

  // side-band rides alongside the series and squaring stages
  always_ff @(posedge clk_i) begin
    base_dly_q[0] <= arg_base;
    diff_dly_q[0] <= arg_diff;
    ctl_dly_q[0]  <= arg_ctl;
    for (int i = 1; i < MID_LAT; i++) begin
      base_dly_q[i] <= base_dly_q[i-1];
      diff_dly_q[i] <= diff_dly_q[i-1];
      ctl_dly_q[i]  <= ctl_dly_q[i-1];
    end
  end

  sbwu_blend #(
    .DATA_BITS (DATA_BITS)
  ) u_blend (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .valid_i  (sq_v),
    .ctl_i    (ctl_dly_q[MID_LAT-1]),
    .base_i   (base_dly_q[MID_LAT-1]),
    .diff_i   (diff_dly_q[MID_LAT-1]),
    .dec_i    (sq_dec),
    .valid_o  (done_o),
    .weight_o (weight_out),
    .status_o (status_o)
  );

  assign weight_out_o = weight_out;

endmodule

`default_nettype wire

@@ rtl/sbwu_checker.sv @@
// Port-level checks for the soft-bound weight update, bound to the top level.
`default_nettype none

module sbwu_checker #(
  parameter int unsigned DATA_BITS = 32
) (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        start,
  input logic                        busy,
  input logic signed [DATA_BITS-1:0] weight_in_i,
  input logic signed [DATA_BITS-1:0] drive_i,
  input logic                        done_o,
  input logic signed [DATA_BITS-1:0] weight_out_o,
  input sbwu_pkg::status_e           status_o,
  input logic                        cfg_valid_i,
  input logic                        cfg_ready_o
);
  import sbwu_pkg::*;

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##TOTAL_LAT done_o)
    else $error("accepted word produced no result on time");

  a_no_spurious: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(start && !busy, TOTAL_LAT))
    else $error("result without a matching input word");

  a_bypass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o != ST_OK)) |-> (weight_out_o == $past(weight_in_i, TOTAL_LAT)))
    else $error("error status but weight was changed");

  a_zero_drive: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_OK) && $past(drive_i == '0, TOTAL_LAT))
      |-> (weight_out_o == $past(weight_in_i, TOTAL_LAT)))
    else $error("zero drive changed the weight");

  a_cfg_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !done_o)
    else $error("config write while results still in flight");

endmodule

bind soft_bound_weight_update sbwu_checker #(.DATA_BITS(DATA_BITS)) u_sbwu_checker (.*);

`default_nettype wire

@@ tb/tb_top.sv @@
// Self-checking testbench for the soft-bound weight update: directed corners, then random words.
`timescale 1ns / 1ps

module tb_top;
  import sbwu_pkg::*;

  localparam logic signed [31:0] W_MIN = 32'sh8000_0000;
  localparam logic signed [31:0] W_MAX = 32'sh7FFF_FFFF;
  localparam logic signed [31:0] W_ONE = 32'sh0001_0000;
  localparam int unsigned STALL_LIMIT = 5000;
  localparam int unsigned RANDOM_WORDS = 1350;

  typedef struct {
    logic signed [31:0] weight;
    status_e            status;
  } update_t;

  logic clk_i = 1'b0;
  logic rst_ni;
  logic start;
  logic busy;
  logic signed [31:0] weight_in_i;
  logic signed [31:0] drive_i;
  logic done_o;
  logic signed [31:0] weight_out_o;
  status_e status_o;
  logic cfg_valid_i;
  logic cfg_ready_o;
  logic [CFG_IDX_BITS-1:0] cfg_index_i;
  logic [31:0] cfg_data_i;

  // local copy of the register file
  logic signed [31:0] band_lo;
  logic signed [31:0] band_hi;
  logic [31:0] flow_step;

  update_t pending_updates[$];
  bit gaps_on;
  int unsigned words_sent, directed_words, config_writes, results_seen;
  int unsigned n_ok, n_empty, n_out, errors, stall_cycles;

  soft_bound_weight_update u_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .start(start),
    .busy(busy),
    .weight_in_i(weight_in_i),
    .drive_i(drive_i),
    .done_o(done_o),
    .weight_out_o(weight_out_o),
    .status_o(status_o),
    .cfg_valid_i(cfg_valid_i),
    .cfg_ready_o(cfg_ready_o),
    .cfg_index_i(cfg_index_i),
    .cfg_data_i(cfg_data_i)
  );

  always #2 clk_i = ~clk_i;

  // exp(-rate * mag) as unsigned Q0.16, 1.0 = 65536
  function automatic logic [16:0] decay_factor(input logic [31:0] rate, input logic [31:0] mag);
    logic [63:0] x, y, t, u;
    longint s;
    int n;
    if (rate == 0 || mag == 0) return 17'h10000;
    if (64'(mag) > (64'd12 << 32) / 64'(rate)) return 17'd0;
    x = 64'(rate) * 64'(mag);
    y = x >> 4;
    if (y == 0) return 17'h10000;
    s = 64'sd1 << 32;
    t = 64'd1 << 32;
    for (n = 1; n <= 13; n++) begin
      t = ((t * y) >> 32) / 64'(n);
      if (n % 2 == 1) s = s - longint'(t);
      else s = s + longint'(t);
    end
    if (s < 0) s = 0;
    if (s > 64'sh0_FFFF_FFFF) s = 64'sh0_FFFF_FFFF;
    u = 64'(s);
    for (n = 0; n < 4; n++) begin
      u = (u * u + (64'd1 << 31)) >> 32;
      if (u > 64'hFFFF_FFFF) u = 64'hFFFF_FFFF;
    end
    return 17'((u + 64'h8000) >> 16);
  endfunction

  function automatic update_t soft_bound_next(input logic signed [31:0] w,
                                              input logic signed [31:0] d);
    update_t r;
    longint lo, hi, wl, res;
    logic [31:0] mag;
    logic [16:0] dec;
    logic [63:0] diff;
    lo = band_lo;
    hi = band_hi;
    wl = w;
    r.weight = w;
    r.status = ST_OK;
    if (lo >= hi) begin
      r.status = ST_EMPTY_BAND;
    end else if (wl < lo || wl > hi) begin
      r.status = ST_OUT_OF_BAND;
    end else if (d != 0) begin
      mag = d[31] ? ~d + 32'd1 : d;
      dec = decay_factor(flow_step, mag);
      if (d < 0) begin
        diff = 64'(wl - lo);
        res = lo + longint'((diff * 64'(dec)) >> 16);
      end else begin
        diff = 64'(hi - wl);
        res = hi - longint'((diff * 64'(dec)) >> 16);
      end
      r.weight = res[31:0];
    end
    return r;
  endfunction

  function automatic int unsigned gap_len();
    int unsigned sel;
    sel = $urandom_range(0, 99);
    if (!gaps_on || sel < 55) return 0;
    if (sel < 88) return $urandom_range(1, 3);
    if (sel < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  function automatic logic signed [31:0] pick_weight();
    int unsigned sel;
    longint lo, hi;
    logic [63:0] span;
    sel = $urandom_range(0, 99);
    lo = band_lo;
    hi = band_hi;
    if (sel < 8) return band_lo;
    if (sel < 16) return band_hi;
    if (sel < 24) return $urandom;
    if (sel < 30 && band_lo != W_MIN) return band_lo - 32'sd1;
    if (sel < 36 && band_hi != W_MAX) return band_hi + 32'sd1;
    if (lo >= hi) return $urandom;
    span = 64'(hi - lo);
    return 32'(lo + longint'({$urandom, $urandom} % (span + 64'd1)));
  endfunction

  // most drives land where the exponent stays below the cap
  function automatic logic signed [31:0] pick_drive();
    int unsigned sel;
    logic [63:0] reach;
    logic [31:0] mag;
    sel = $urandom_range(0, 99);
    if (sel < 5) return '0;
    if (sel < 10) return sel[0] ? W_MAX : W_MIN;
    if (sel < 28) return $urandom;
    reach = (flow_step == 0) ? 64'h7FFF_FFFE : (64'd12 << 32) / 64'(flow_step);
    if (reach > 64'h7FFF_FFFE) reach = 64'h7FFF_FFFE;
    if (sel < 36) mag = 32'(reach) + 32'(sel[0]);
    else if (sel < 60) mag = $urandom_range(0, 32'(reach >> $urandom_range(0, 24)));
    else mag = $urandom_range(0, 32'(reach));
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  task automatic send_word(input logic signed [31:0] w, input logic signed [31:0] d);
    int unsigned gap;
    gap = gap_len();
    if (gap != 0) begin
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start = 1'b1;
    weight_in_i = w;
    drive_i = d;
    do @(posedge clk_i); while (busy);
    pending_updates.insert(pending_updates.size(), soft_bound_next(w, d));
    words_sent++;
    @(negedge clk_i);
  endtask

  task automatic settle_pipeline();
    start = 1'b0;
    while (pending_updates.size() != 0) @(posedge clk_i);
    repeat (TOTAL_LAT + 4) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_valid_i = 1'b1;
    cfg_index_i = idx;
    cfg_data_i = data;
    do @(posedge clk_i); while (!cfg_ready_o);
    case (idx)
      CFG_LOWER: band_lo = data;
      CFG_UPPER: band_hi = data;
      CFG_RATE:  flow_step = data;
      default: ;
    endcase
    config_writes++;
    @(negedge clk_i);
    cfg_valid_i = 1'b0;
  endtask

  task automatic set_config(input logic signed [31:0] lo, input logic signed [31:0] hi,
                            input logic [31:0] rate);
    settle_pipeline();
    write_reg(CFG_LOWER, lo);
    write_reg(CFG_UPPER, hi);
    write_reg(CFG_RATE, rate);
  endtask

  task automatic test_reset_config();
    send_word(32'sd32768, 32'sd0);
    send_word(32'sd32768, W_ONE);
    send_word(32'sd32768, -W_ONE);
    send_word(32'sd0, -W_ONE);
    send_word(W_ONE, W_ONE);
    send_word(-32'sd1, 32'sd100);
    send_word(W_ONE + 32'sd1, 32'sd100);
    send_word(32'sd32768, W_MIN);
    send_word(32'sd32768, W_MAX);
    settle_pipeline();
  endtask

  task automatic test_extremes();
    set_config(W_MIN, W_MAX, 32'hFFFF_FFFF);
    send_word(W_MIN, W_MAX);
    send_word(W_MAX, W_MIN);
    send_word(32'sd0, 32'sd1);
    send_word(32'sd0, -32'sd1);
    set_config(W_MIN, W_MAX, 32'd0);
    send_word(32'sd12345, W_MIN);
    // exponent truncates to zero, then just above it
    set_config(32'sd0, W_ONE, 32'd1);
    send_word(32'sd40000, 32'sd1);
    send_word(32'sd40000, -32'sd15);
    send_word(32'sd40000, 32'sd16);
    settle_pipeline();
  endtask

  task automatic test_empty_band();
    set_config(32'sh1000, 32'sh1000, 32'd6554);
    send_word(32'sh1000, 32'sd5);
    set_config(32'sd5, -32'sd5, 32'd6554);
    send_word(32'sd0, 32'sd5);
    send_word(W_MIN, W_MAX);
    settle_pipeline();
  endtask

  task automatic test_random();
    logic signed [31:0] a, b, lo, hi;
    logic [31:0] rate;
    int unsigned sel, count;
    while (words_sent - directed_words < RANDOM_WORDS) begin
      a = $urandom;
      b = $urandom;
      sel = $urandom_range(0, 99);
      if (sel < 5) begin
        lo = a;
        hi = a;
      end else if (sel < 10) begin
        lo = (a > b) ? a : b;
        hi = (a > b) ? b : a;
      end else if (sel < 20) begin
        lo = W_MIN;
        hi = W_MAX;
      end else if (sel < 50) begin
        a = $urandom_range(0, 262144);
        lo = -a;
        hi = lo + 32'($urandom_range(1, 524288));
      end else begin
        lo = (a < b) ? a : b;
        hi = (a < b) ? b : a;
      end
      sel = $urandom_range(0, 99);
      if (sel < 8) rate = 32'd0;
      else if (sel < 16) rate = 32'hFFFF_FFFF;
      else if (sel < 24) rate = 32'd1;
      else if (sel < 70) rate = $urandom_range(1, 262144);
      else rate = $urandom;
      set_config(lo, hi, rate);
      gaps_on = ($urandom_range(0, 99) >= 30);
      count = $urandom_range(90, 135);
      repeat (count) send_word(pick_weight(), pick_drive());
    end
    settle_pipeline();
  endtask

  always @(posedge clk_i) begin : result_check
    update_t want;
    if (rst_ni && done_o) begin
      results_seen++;
      if (pending_updates.size() == 0) begin
        $display("%0t: unexpected result: weight %h status %0d", $time, weight_out_o,
                 status_o);
        errors++;
      end else begin
        want = pending_updates.pop_front();
        if (weight_out_o !== want.weight) begin
          $display("%0t: weight_out mismatch: expected %h actual %h", $time, want.weight,
                   weight_out_o);
          errors++;
        end
        if (status_o !== want.status) begin
          $display("%0t: status mismatch: expected %0d actual %0d", $time, want.status,
                   status_o);
          errors++;
        end
        case (status_o)
          ST_OK:          n_ok++;
          ST_EMPTY_BAND:  n_empty++;
          ST_OUT_OF_BAND: n_out++;
          default: ;
        endcase
      end
    end
  end

  // no word moving on any channel for too long
  always @(posedge clk_i) begin
    if (!rst_ni || (start && !busy) || done_o || (cfg_valid_i && cfg_ready_o)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t: no handshake for %0d cycles, %0d results pending", $time, stall_cycles,
               pending_updates.size());
      $display("TEST FAILED");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    rst_ni = 1'b0;
    start = 1'b0;
    weight_in_i = '0;
    drive_i = '0;
    cfg_valid_i = 1'b0;
    cfg_index_i = CFG_LOWER;
    cfg_data_i = '0;
    band_lo = 32'sd0;
    band_hi = W_ONE;
    flow_step = RATE_RESET;
    gaps_on = 1'b1;
    stall_cycles = 0;
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    test_reset_config();
    test_extremes();
    test_empty_band();
    directed_words = words_sent;
    test_random();

    $display("covered %0d words (%0d directed) across %0d register writes, %0d results checked",
             words_sent, directed_words, config_writes, results_seen);
    $display("status mix: ok %0d, empty band %0d, out of band %0d; %0d mismatches",
             n_ok, n_empty, n_out, errors);
    if (errors == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
